// ----- design/satellite_signal_table_unit_defines.svh -----
// Assertion macros shared by the satellite signal table checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SATELLITE_SIGNAL_TABLE_UNIT_DEFINES_SVH
`define SATELLITE_SIGNAL_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sst_pkg.sv -----
// Shared types and constants of the satellite signal table.
// No dependencies; imported by the memory, the compare unit, the top level and the testbench.
`default_nettype none
package sst_pkg;

  localparam int unsigned DefTableDepth = 32;
  localparam logic [31:0] MAX_AGE_RST = 32'(20 * 1000);

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_PURGE  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SORT_INSERT = 2'd0,
    SORT_ID     = 2'd1,
    SORT_SIGNAL = 2'd2,
    SORT_RSVD   = 2'd3
  } sort_e;

  typedef enum logic [0:0] {
    REG_MAX_AGE = 1'b0,
    REG_SORT    = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPACT,
    ST_SELECT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  sig;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic match;
    logic aged;
    logic cand;
  } cmp_res_t;

endpackage
`default_nettype wire

// ----- design/sst_table_ram.sv -----
// Entry memory of the satellite signal table: one write and one registered read port.
// Depends on sst_pkg for the entry type.
`default_nettype none
module sst_table_ram
  import sst_pkg::*;
#(
  parameter int unsigned TableDepth = DefTableDepth,
  parameter int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output entry_t                rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  entry_t                wr_data_i
);

  entry_t mem_q [TableDepth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ----- design/sst_key_cmp.sv -----
// Shared compare unit: identifier match, wrapped age test and sort key ranking.
// Depends on sst_pkg for the entry, sort and result types.
`default_nettype none
module sst_key_cmp
  import sst_pkg::*;
#(
  parameter int unsigned TableDepth = DefTableDepth,
  parameter int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  parameter int unsigned KeyW       = 8 + AddrW
) (
  input  entry_t                entry_i,
  input  wire logic [AddrW-1:0] idx_i,
  input  sort_e                 sort_i,
  input  wire logic [7:0]       sid_i,
  input  wire logic [31:0]      now_i,
  input  wire logic [31:0]      max_age_i,
  input  wire logic             have_last_i,
  input  wire logic [KeyW-1:0]  last_key_i,
  input  wire logic             have_best_i,
  input  wire logic [KeyW-1:0]  best_key_i,
  output cmp_res_t              res_o,
  output logic [KeyW-1:0]       key_o
);

  logic [7:0]  prim;
  logic [31:0] age;

  always_comb begin
    unique case (sort_i)
      SORT_ID:     prim = entry_i.id;
      SORT_SIGNAL: prim = ~entry_i.sig;
      default:     prim = 8'd0;
    endcase
  end

  // The position breaks ties, so every key is unique and ties keep insertion order.
  assign key_o     = {prim, idx_i};
  assign age       = now_i - entry_i.stamp;
  assign res_o.aged  = age > max_age_i;
  assign res_o.match = entry_i.id == sid_i;
  assign res_o.cand  = (!have_last_i || key_o > last_key_i) &&
                       (!have_best_i || key_o < best_key_i);

endmodule
`default_nettype wire

// ----- design/satellite_signal_table_unit.sv -----
// Satellite signal table: a report or a purge makes one compaction pass through the entry
// memory at one entry a cycle. A readout emits n words for n stored entries, each found
// by a full scan through the shared compare unit and then handed over; an empty readout,
// or an unused operation, gives its single word in the cycle after it is taken.
// One item is taken at a time; config may be written only while idle.
// Depends on sst_pkg, sst_table_ram and sst_key_cmp.
`default_nettype none
module satellite_signal_table_unit
  import sst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  sat_id_i,
  input  wire logic [7:0]  signal_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic             entry_valid_o,
  output logic [7:0]       entry_id_o,
  output logic [7:0]       entry_signal_o,
  output logic [5:0]       entry_count_o,
  output logic             last_of_run_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KeyW  = 8 + AddrW;

  state_e            state_q, state_d;
  logic [31:0]       max_age_q;
  sort_e             sort_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]   emitted_q, emitted_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  pend_idx_q, pend_idx_d;
  logic              found_q, found_d;
  op_e               op_q, op_d;
  logic [7:0]        sid_q, sid_d;
  logic [7:0]        sig_q, sig_d;
  logic [31:0]       now_q, now_d;
  logic              have_last_q, have_last_d;
  logic [KeyW-1:0]   last_key_q, last_key_d;
  logic              have_best_q, have_best_d;
  logic [KeyW-1:0]   best_key_q, best_key_d;
  logic [7:0]        best_id_q, best_id_d;
  logic [7:0]        best_sig_q, best_sig_d;
  logic              out_valid_q, out_valid_d;
  logic              out_status_q, out_status_d;
  logic              out_evalid_q, out_evalid_d;
  logic [7:0]        out_id_q, out_id_d;
  logic [7:0]        out_sig_q, out_sig_d;
  logic              out_last_q, out_last_d;

  logic              rd_en, wr_en, drop;
  logic [AddrW-1:0]  wr_addr;
  entry_t            rd_data, wr_data;
  cmp_res_t          cmp_res;
  logic [KeyW-1:0]   cmp_key;

  sst_table_ram #(
    .TableDepth (TABLE_DEPTH),
    .AddrW      (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_ptr_q[AddrW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  sst_key_cmp #(
    .TableDepth (TABLE_DEPTH),
    .AddrW      (AddrW),
    .KeyW       (KeyW)
  ) u_cmp (
    .entry_i     (rd_data),
    .idx_i       (pend_idx_q),
    .sort_i      (sort_q),
    .sid_i       (sid_q),
    .now_i       (now_q),
    .max_age_i   (max_age_q),
    .have_last_i (have_last_q),
    .last_key_i  (last_key_q),
    .have_best_i (have_best_q),
    .best_key_i  (best_key_q),
    .res_o       (cmp_res),
    .key_o       (cmp_key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RST;
      sort_q    <= SORT_INSERT;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_MAX_AGE: max_age_q <= cfg_wdata_i;
        REG_SORT:    sort_q    <= sort_e'(cfg_wdata_i[1:0]);
        default:     max_age_q <= max_age_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    wr_ptr_q     <= wr_ptr_d;
    emitted_q    <= emitted_d;
    pend_idx_q   <= pend_idx_d;
    found_q      <= found_d;
    op_q         <= op_d;
    sid_q        <= sid_d;
    sig_q        <= sig_d;
    now_q        <= now_d;
    have_last_q  <= have_last_d;
    last_key_q   <= last_key_d;
    have_best_q  <= have_best_d;
    best_key_q   <= best_key_d;
    best_id_q    <= best_id_d;
    best_sig_q   <= best_sig_d;
    out_status_q <= out_status_d;
    out_evalid_q <= out_evalid_d;
    out_id_q     <= out_id_d;
    out_sig_q    <= out_sig_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    emitted_d    = emitted_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    found_d      = found_q;
    op_d         = op_q;
    sid_d        = sid_q;
    sig_d        = sig_q;
    now_d        = now_q;
    have_last_d  = have_last_q;
    last_key_d   = last_key_q;
    have_best_d  = have_best_q;
    best_key_d   = best_key_q;
    best_id_d    = best_id_q;
    best_sig_d   = best_sig_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_evalid_d = out_evalid_q;
    out_id_d     = out_id_q;
    out_sig_d    = out_sig_q;
    out_last_d   = out_last_q;
    in_ready_o   = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = wr_ptr_q[AddrW-1:0];
    wr_data      = rd_data;
    drop         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d         = op_e'(operation_i);
          sid_d        = sat_id_i;
          sig_d        = signal_i;
          now_d        = now_ms_i;
          rd_ptr_d     = '0;
          wr_ptr_d     = '0;
          emitted_d    = '0;
          pend_d       = 1'b0;
          found_d      = 1'b0;
          have_last_d  = 1'b0;
          have_best_d  = 1'b0;
          out_status_d = 1'b0;
          out_evalid_d = 1'b0;
          out_id_d     = 8'd0;
          out_sig_d    = 8'd0;
          out_last_d   = 1'b1;
          unique case (op_e'(operation_i)) inside
            OP_REPORT, OP_PURGE: state_d = ST_COMPACT;
            OP_READ: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                state_d     = ST_OUT;
              end else begin
                state_d = ST_SELECT;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              state_d     = ST_OUT;
            end
          endcase
        end
      end

      ST_COMPACT: begin
        // Entries stream from the read pointer to the write pointer, skipping dropped ones.
        pend_d = 1'b0;
        if (rd_ptr_q < count_q) begin
          rd_en    = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          if (op_q == OP_REPORT) begin
            if (cmp_res.match) begin
              found_d = 1'b1;
              wr_data = '{id: rd_data.id, sig: sig_q, stamp: now_q};
            end
            drop = cmp_res.match && (sig_q == 8'd0);
          end else begin
            drop = cmp_res.aged;
          end
          if (!drop) begin
            wr_en    = 1'b1;
            wr_ptr_d = wr_ptr_q + 1'b1;
          end
        end else if (rd_ptr_q == count_q) begin
          count_d = wr_ptr_q;
          if (op_q == OP_REPORT && !found_q) begin
            if (wr_ptr_q < CntW'(TABLE_DEPTH)) begin
              wr_en   = 1'b1;
              wr_data = '{id: sid_q, sig: sig_q, stamp: now_q};
              count_d = wr_ptr_q + 1'b1;
            end else begin
              out_status_d = 1'b1;
            end
          end
          out_valid_d = 1'b1;
          state_d     = ST_OUT;
        end
      end

      ST_SELECT: begin
        // One scan picks the smallest key above the one emitted last.
        pend_d = 1'b0;
        if (rd_ptr_q < count_q) begin
          rd_en      = 1'b1;
          rd_ptr_d   = rd_ptr_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[AddrW-1:0];
        end
        if (pend_q) begin
          if (cmp_res.cand) begin
            have_best_d = 1'b1;
            best_key_d  = cmp_key;
            best_id_d   = rd_data.id;
            best_sig_d  = rd_data.sig;
          end
        end else if (rd_ptr_q == count_q) begin
          out_evalid_d = 1'b1;
          out_id_d     = best_id_q;
          out_sig_d    = best_sig_q;
          out_last_d   = (emitted_q + 1'b1) == count_q;
          emitted_d    = emitted_q + 1'b1;
          have_last_d  = 1'b1;
          last_key_d   = best_key_q;
          out_valid_d  = 1'b1;
          state_d      = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            rd_ptr_d    = '0;
            pend_d      = 1'b0;
            have_best_d = 1'b0;
            state_d     = ST_SELECT;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign entry_valid_o  = out_evalid_q;
  assign entry_id_o     = out_id_q;
  assign entry_signal_o = out_sig_q;
  assign entry_count_o  = 6'(count_q);
  assign last_of_run_o  = out_last_q;

endmodule
`default_nettype wire

// ----- design/sst_checker.sv -----
// Port-level checker of the satellite signal table, bound to the top level.
// Depends on satellite_signal_table_unit_defines.svh for the assertion macros.
`default_nettype none
`include "satellite_signal_table_unit_defines.svh"
module sst_checker #(
  parameter int unsigned TableDepth = 32
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       status_o,
  input wire logic       entry_valid_o,
  input wire logic [7:0] entry_id_o,
  input wire logic [7:0] entry_signal_o,
  input wire logic [5:0] entry_count_o,
  input wire logic       last_of_run_o
);

  `SST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result word dropped before it was taken")
  `SST_ASSERT_NOW(a_busy_excl, clk_i, rst_ni, out_valid_o, !in_ready_o, "input taken while a result word is pending")
  `SST_ASSERT_NOW(a_full_flag, clk_i, rst_ni, out_valid_o && status_o, !entry_valid_o && last_of_run_o, "full flag on a readout word")
  `SST_ASSERT_NOW(a_empty_word, clk_i, rst_ni, out_valid_o && !entry_valid_o, entry_id_o == 8'd0 && entry_signal_o == 8'd0, "word without entry carries data")
  `SST_ASSERT_NOW(a_count_max, clk_i, rst_ni, out_valid_o, {1'b0, entry_count_o} <= 7'(TableDepth) || TableDepth > 63, "entry count above table depth")

endmodule

bind satellite_signal_table_unit sst_checker #(.TableDepth(TABLE_DEPTH)) u_sst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .entry_valid_o  (entry_valid_o),
  .entry_id_o     (entry_id_o),
  .entry_signal_o (entry_signal_o),
  .entry_count_o  (entry_count_o),
  .last_of_run_o  (last_of_run_o)
);
`default_nettype wire

// ----- tb/tb_satellite_signal_table_unit.sv -----
// Self-checking testbench for satellite_signal_table_unit: directed and random
// reports, purges and readouts against an in-bench table predictor. Depends on sst_pkg.
module tb_satellite_signal_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int Depth = 32;

  typedef struct packed {
    logic       status;
    logic       valid;
    logic [7:0] id;
    logic [7:0] sig;
    logic [5:0] count;
    logic       last;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic [7:0] sat_id_i = '0;
  logic [7:0] signal_i = '0;
  logic [31:0] now_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o, entry_valid_o, last_of_run_o;
  logic [7:0] entry_id_o, entry_signal_o;
  logic [5:0] entry_count_o;

  satellite_signal_table_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Predicted table contents and settings.
  logic [7:0] tbl_id[Depth];
  logic [7:0] tbl_sig[Depth];
  logic [31:0] tbl_stamp[Depth];
  int tbl_used;
  logic [31:0] age_limit;
  sort_e order_sel;

  word_t pending_words[$];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  int hold_cycles = 0;
  logic [31:0] clock_ms = 0;

  function automatic word_t make_word(logic st, logic v, logic [7:0] id, logic [7:0] sg,
                                      logic lst);
    word_t w;
    w.status = st;
    w.valid = v;
    w.id = id;
    w.sig = sg;
    w.count = 6'(tbl_used);
    w.last = lst;
    return w;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < tbl_used; i++) begin
      tbl_id[i] = tbl_id[i + 1];
      tbl_sig[i] = tbl_sig[i + 1];
      tbl_stamp[i] = tbl_stamp[i + 1];
    end
    tbl_used--;
  endfunction

  function automatic bit ranks_ahead(int a, int b);
    if (order_sel == SORT_ID) return tbl_id[a] < tbl_id[b];
    if (order_sel == SORT_SIGNAL) return tbl_sig[a] > tbl_sig[b];
    return 1'b0;
  endfunction

  function automatic void predict_table(op_e op, logic [7:0] sid, logic [7:0] sg,
                                        logic [31:0] now);
    int pos;
    int j;
    int idx[Depth];
    logic st;
    pos = -1;
    st = 1'b0;
    case (op)
      OP_REPORT: begin
        for (int i = 0; i < tbl_used; i++)
          if (pos < 0 && tbl_id[i] == sid) pos = i;
        if (pos >= 0) begin
          if (sg == 0) drop_entry(pos);
          else begin
            tbl_sig[pos] = sg;
            tbl_stamp[pos] = now;
          end
        end else if (tbl_used >= Depth) begin
          st = 1'b1;
        end else begin
          tbl_id[tbl_used] = sid;
          tbl_sig[tbl_used] = sg;
          tbl_stamp[tbl_used] = now;
          tbl_used++;
        end
        pending_words.push_back(make_word(st, 0, 0, 0, 1));
      end
      OP_PURGE: begin
        j = 0;
        while (j < tbl_used) begin
          if (32'(now - tbl_stamp[j]) > age_limit) drop_entry(j);
          else j++;
        end
        pending_words.push_back(make_word(0, 0, 0, 0, 1));
      end
      OP_READ: begin
        if (tbl_used == 0) pending_words.push_back(make_word(0, 0, 0, 0, 1));
        else begin
          // Stable insertion sort over entry indexes.
          for (int i = 0; i < tbl_used; i++) begin
            j = i;
            while (j > 0 && ranks_ahead(i, idx[j - 1])) begin
              idx[j] = idx[j - 1];
              j--;
            end
            idx[j] = i;
          end
          for (int i = 0; i < tbl_used; i++)
            pending_words.push_back(make_word(0, 1, tbl_id[idx[i]], tbl_sig[idx[i]],
                                              i + 1 == tbl_used));
        end
      end
      default: pending_words.push_back(make_word(0, 0, 0, 0, 1));
    endcase
  endfunction

  task automatic send_item(op_e op, logic [7:0] sid, logic [7:0] sg, logic [31:0] now);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // Valid drops between one item being taken and the next one being offered.
    repeat (gap + 1) @(posedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    sat_id_i <= sid;
    signal_i <= sg;
    now_ms_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_table(op, sid, sg, now);
    items_sent++;
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] val);
    int guard;
    guard = 0;
    while (pending_words.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (1200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_AGE) age_limit = val;
    else order_sel = sort_e'(val[1:0]);
  endtask

  // Receiver: random stalls, plus a long hold when hold_cycles is set.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 15) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    word_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, entry_valid_o, entry_id_o, entry_signal_o, entry_count_o,
              last_of_run_o};
      words_seen++;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected word %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed_reports();
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_REPORT, 8'd0, 8'd255, 32'd0);
    send_item(OP_REPORT, 8'd255, 8'd1, 32'hFFFF_FFFF);
    send_item(OP_REPORT, 8'd17, 8'd0, 32'd100);
    send_item(OP_REPORT, 8'd42, 8'd128, 32'd200);
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_REPORT, 8'd17, 8'd0, 32'd300);
    send_item(OP_REPORT, 8'd42, 8'd200, 32'd400);
    send_item(OP_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_PURGE, 0, 0, 32'd25000);
    send_item(OP_READ, 0, 0, 0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < 36; i++)
      send_item(OP_REPORT, 8'(i * 7), 8'($urandom_range(1, 255)), clock_ms + i);
    send_item(OP_REPORT, 8'd14, 8'd0, clock_ms);
    send_item(OP_REPORT, 8'd21, 8'd9, clock_ms);
    send_item(OP_READ, 0, 0, 0);
  endtask

  task automatic test_sort_orders();
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_SORT, 32'(s));
      send_item(OP_READ, 0, 0, 0);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_REPORT, 8'd3, 8'd3, 32'd5);
    send_item(OP_READ, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    op_e op;
    logic [7:0] sg;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 30) begin
        write_reg(REG_SORT, 32'($urandom_range(0, 3)));
        write_reg(REG_MAX_AGE, ($urandom_range(0, 3) == 0) ? $urandom() :
                  32'($urandom_range(0, 3000)));
      end
      clock_ms += $urandom_range(0, 200);
      pick = $urandom_range(0, 19);
      op = pick < 13 ? OP_REPORT : pick < 16 ? OP_PURGE : pick < 19 ? OP_READ : OP_NONE;
      sg = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      // Mostly a small id pool so reports hit known satellites.
      send_item(op, ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
                8'($urandom_range(0, 40)), sg,
                ($urandom_range(0, 9) == 0) ? $urandom() : clock_ms);
    end
  endtask

  initial begin
    int guard;
    tbl_used = 0;
    age_limit = MAX_AGE_RST;
    order_sel = SORT_INSERT;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_reports();
    test_full_table();
    test_sort_orders();
    write_reg(REG_MAX_AGE, 32'd0);
    send_item(OP_PURGE, 0, 0, clock_ms + 50);
    write_reg(REG_MAX_AGE, 32'hFFFF_FFFF);
    test_backpressure();
    test_random(200);
    guard = 0;
    while (pending_words.size() != 0 && guard < 500000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (1200) @(posedge clk_i);
    if (pending_words.size() != 0) errors++;
    $display("Sent %0d items and checked %0d result words over reports, purges,",
             items_sent, words_seen);
    $display("full-table drops, all sort orders and a long output stall.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- satellite_signal_table_unit.f -----
+incdir+design
design/sst_pkg.sv
design/sst_table_ram.sv
design/sst_key_cmp.sv
design/satellite_signal_table_unit.sv
design/sst_checker.sv
tb/tb_satellite_signal_table_unit.sv
